[sv/pact_pkg.sv]
// ---------------------------------------------------------------------------
// pact_pkg: shared types and constants
// Item, configuration and status types used by the camera trigger modules.
// ---------------------------------------------------------------------------
package pact_pkg;

	localparam int POS_W      = 32;
	localparam int CFG_W      = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int MODE_W     = 2;
	localparam int STEP_W     = 31;
	localparam int PITCH_W    = 31;
	localparam int LIMIT_W    = 8;
	localparam int SHOT_W     = 16;
	localparam int TOL_W      = 7;
	localparam int FIRE_CNT_W = 32;
	localparam int STRAY_W    = 16;
	localparam int WATCH_W    = LIMIT_W + PITCH_W;
	localparam int SCALE_W    = PITCH_W + 8;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	localparam logic [TOL_W-1:0] PERCENT = 7'd100;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_DISTANCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TERMINAL_PITCH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLIP_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOT_TOTAL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_ONLY  = 3'd6;

	localparam logic [MODE_W-1:0] MODE_INSPECT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_NSHOT   = 2'd2;

	localparam logic [TOL_W-1:0] TOL_RESET = 7'd10;

	localparam logic OP_START = 1'b1;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_MISSING = 2'd1,
		ERR_SLIP    = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_PAUSED = 2'd1,
		KIND_START  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic              sensor_edge;
		logic [POS_W-1:0]  position;
	} item_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [STEP_W-1:0]  step;
		logic [PITCH_W-1:0] pitch;
		logic [LIMIT_W-1:0] limit;
		logic [SHOT_W-1:0]  shot_total;
		logic               encoder_only;
		logic [WATCH_W-1:0] watch;
		logic [SCALE_W-1:0] hi;
		logic [SCALE_W-1:0] lo;
		logic               lo_ok;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic                  fire;
		logic                  fire_pause;
		logic                  run;
		logic [FIRE_CNT_W-1:0] insp;
		logic [SHOT_W-1:0]     shots;
		logic [STRAY_W-1:0]    stray;
	} status_t;

endpackage

[sv/pact_cfg.sv]
// ---------------------------------------------------------------------------
// pact_cfg: configuration registers
// Holds the registers and the products derived from them.
// ---------------------------------------------------------------------------
module pact_cfg
	import pact_pkg::*;
#(
	parameter int DEFAULT_SLIP_LIMIT = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	logic [MODE_W-1:0]  mode_q;
	logic [STEP_W-1:0]  step_q;
	logic [PITCH_W-1:0] pitch_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [SHOT_W-1:0]  shot_q;
	logic [TOL_W-1:0]   tol_q;
	logic               enc_q;

	logic [LIMIT_W-1:0] lim_eff;
	logic [LIMIT_W-1:0] lim_q;
	logic [WATCH_W-1:0] watch_q;
	logic [SCALE_W-1:0] tolx_q;
	logic [SCALE_W-1:0] p100_q;
	logic [SCALE_W-1:0] hi_q;
	logic [SCALE_W-1:0] lo_q;
	logic               lo_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			step_q  <= '0;
			pitch_q <= '0;
			limit_q <= '0;
			shot_q  <= '0;
			tol_q   <= TOL_RESET;
			enc_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TRIGGER_MODE:   mode_q  <= cfg_data[MODE_W-1:0];
				CFG_STEP_DISTANCE:  step_q  <= cfg_data[STEP_W-1:0];
				CFG_TERMINAL_PITCH: pitch_q <= cfg_data[PITCH_W-1:0];
				CFG_SLIP_LIMIT:     limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_SHOT_TOTAL:     shot_q  <= cfg_data[SHOT_W-1:0];
				CFG_TOLERANCE:      tol_q   <= cfg_data[TOL_W-1:0];
				CFG_ENCODER_ONLY:   enc_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign lim_eff = (limit_q == '0) ? LIMIT_W'(DEFAULT_SLIP_LIMIT) : limit_q;

	// products are registered from the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q   <= '0;
			watch_q <= '0;
			tolx_q  <= '0;
			p100_q  <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
			lo_ok_q <= 1'b0;
		end else begin
			lim_q   <= lim_eff;
			watch_q <= WATCH_W'(lim_eff) * WATCH_W'(pitch_q);
			tolx_q  <= SCALE_W'(pitch_q) * SCALE_W'(tol_q);
			p100_q  <= SCALE_W'(pitch_q) * SCALE_W'(PERCENT);
			hi_q    <= p100_q + tolx_q;
			lo_q    <= p100_q - tolx_q;
			lo_ok_q <= p100_q > tolx_q;
		end
	end

	always_comb begin
		cfg.mode         = mode_q;
		cfg.step         = step_q;
		cfg.pitch        = pitch_q;
		cfg.limit        = lim_q;
		cfg.shot_total   = shot_q;
		cfg.encoder_only = enc_q;
		cfg.watch        = watch_q;
		cfg.hi           = hi_q;
		cfg.lo           = lo_q;
		cfg.lo_ok        = lo_ok_q;
	end

endmodule

[sv/pact_front.sv]
// ---------------------------------------------------------------------------
// pact_front: input stage
// Takes items off the input channel, classifies them, pushes to the queue.
// ---------------------------------------------------------------------------
module pact_front
	import pact_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  logic [POS_W-1:0] position,
	input  logic             sensor_edge,
	input  logic             motor_paused,
	input  q_stat_t          q_stat,
	output logic             push,
	output item_t            push_item
);

	logic  valid_s1;
	item_t item_s1;
	kind_t kind;

	always_comb begin
		if (operation == OP_START) begin
			kind = KIND_START;
		end else if (motor_paused) begin
			kind = KIND_PAUSED;
		end else begin
			kind = KIND_TICK;
		end
	end

	assign in_stall  = valid_s1 && q_stat.full;
	assign push      = valid_s1 && !q_stat.full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.kind        <= kind;
			item_s1.sensor_edge <= sensor_edge;
			item_s1.position    <= position;
		end
	end

endmodule

[sv/pact_queue.sv]
// ---------------------------------------------------------------------------
// pact_queue: item queue
// Short FIFO between the front and back parts.
// ---------------------------------------------------------------------------
module pact_queue
	import pact_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head,
	output q_stat_t q_stat
);

	item_t              slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head         = slots_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (Q_PTR_W+1)'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule

[sv/pact_back.sv]
// ---------------------------------------------------------------------------
// pact_back: run engine
// Updates run state per item, then checks watchdog and slip in later stages.
// ---------------------------------------------------------------------------
module pact_back
	import pact_pkg::*;
#(
	parameter int POSITION_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  item_t                 head,
	input  q_stat_t               q_stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  camera_fire,
	output logic                  pause_request,
	output logic [1:0]            error_code,
	output logic                  run_active,
	output logic [FIRE_CNT_W-1:0] inspection_count,
	output logic [SHOT_W-1:0]     shots_taken,
	output logic [STRAY_W-1:0]    stray_edges
);

	localparam int PW    = POSITION_BITS;
	localparam int CMP_W = (PW > STEP_W) ? PW : STEP_W;
	localparam int ACT_W = PW + 7;

	logic en;

	// run state
	logic                  edge_pend_q;
	logic                  run_q;
	logic                  skip_q;
	logic                  armed_q;
	logic [PW-1:0]         last_anchor_q;
	logic [PW-1:0]         fire_anchor_q;
	logic [SHOT_W-1:0]     shot_q;
	logic [FIRE_CNT_W-1:0] fire_tot_q;
	logic [STRAY_W-1:0]    stray_q;
	logic [LIMIT_W-1:0]    slip_q;

	logic                  edge_pend_d;
	logic                  run_d;
	logic                  skip_d;
	logic                  armed_d;
	logic [PW-1:0]         last_anchor_d;
	logic [PW-1:0]         fire_anchor_d;
	logic [SHOT_W-1:0]     shot_d;
	logic [FIRE_CNT_W-1:0] fire_tot_d;
	logic [STRAY_W-1:0]    stray_d;

	logic [PW-1:0]     pos;
	logic signed [PW:0] d_anchor;
	logic signed [PW:0] d_fire;
	logic [PW:0]       fire_neg;
	logic [PW-1:0]     fire_dist;
	logic              fire_far;
	logic              step_zero;
	logic              active_mode;
	logic              ep;
	logic              chk_fire;
	logic              armed_e;
	logic              reanch;
	logic              fire;
	logic              fire_pause;
	logic              wd_chk;
	logic              slip_chk;
	logic              slip_clr;
	logic [SHOT_W-1:0] shot_inc;

	// stage 2: distance to anchor, flags
	logic              valid_s2;
	status_t           stat_s2;
	logic signed [PW:0] d_s2;
	logic              wd_chk_s2;
	logic              slip_chk_s2;
	logic              slip_clr_s2;

	// stage 3: absolute distance, watchdog
	logic              valid_s3;
	status_t           stat_s3;
	logic [PW-1:0]     abs_s3;
	logic              wd_hit_s3;
	logic              slip_chk_s3;
	logic              slip_clr_s3;
	logic [PW:0]       d_neg;
	logic [PW-1:0]     abs_d;

	// stage 4: distance scaled by 100
	logic              valid_s4;
	status_t           stat_s4;
	logic [ACT_W-1:0]  act100_s4;
	logic              wd_hit_s4;
	logic              slip_chk_s4;
	logic              slip_clr_s4;

	// output stage
	logic               miss;
	logic               slip_hit;
	logic [LIMIT_W-1:0] slip_d;
	err_t               err_d;
	logic               out_valid_q;
	logic               fire_q;
	logic               pause_q;
	err_t               err_q;
	logic               run_out_q;
	logic [FIRE_CNT_W-1:0] insp_q;
	logic [SHOT_W-1:0]  shots_q;
	logic [STRAY_W-1:0] stray_out_q;

	assign en  = !out_valid_q || !out_stall;
	assign pop = en && !q_stat.empty;

	assign pos       = head.position[PW-1:0];
	assign d_anchor  = signed'({pos[PW-1], pos}) - signed'({last_anchor_q[PW-1], last_anchor_q});
	assign d_fire    = signed'({pos[PW-1], pos}) - signed'({fire_anchor_q[PW-1], fire_anchor_q});
	assign fire_neg  = -d_fire;
	assign fire_dist = d_fire[PW] ? fire_neg[PW-1:0] : d_fire[PW-1:0];
	assign fire_far  = CMP_W'(fire_dist) >= CMP_W'(cfg.step);
	assign step_zero = (cfg.step == '0);
	assign active_mode = (cfg.mode == MODE_INSPECT) || (cfg.mode == MODE_NSHOT);
	assign ep        = edge_pend_q || head.sensor_edge;
	assign shot_inc  = shot_q + 1'b1;

	always_comb begin
		edge_pend_d   = edge_pend_q;
		run_d         = run_q;
		skip_d        = skip_q;
		armed_d       = armed_q;
		last_anchor_d = last_anchor_q;
		fire_anchor_d = fire_anchor_q;
		shot_d        = shot_q;
		fire_tot_d    = fire_tot_q;
		stray_d       = stray_q;
		chk_fire      = 1'b0;
		armed_e       = armed_q;
		reanch        = 1'b0;
		fire          = 1'b0;
		fire_pause    = 1'b0;
		wd_chk        = 1'b0;
		slip_chk      = 1'b0;
		slip_clr      = 1'b0;
		case (head.kind)
			KIND_START: begin
				run_d       = 1'b1;
				skip_d      = 1'b1;
				armed_d     = 1'b0;
				shot_d      = '0;
				edge_pend_d = 1'b0;
				slip_clr    = 1'b1;
			end
			KIND_PAUSED: begin
				edge_pend_d = ep;
			end
			KIND_TICK: begin
				if (!run_q || !active_mode) begin
					edge_pend_d = 1'b0;
					if (ep && stray_q != '1) begin
						stray_d = stray_q + 1'b1;
					end
				end else if (cfg.encoder_only) begin
					// edges stay latched; re-arm at the current position
					edge_pend_d = ep;
					armed_d     = 1'b1;
					armed_e     = 1'b1;
					reanch      = !armed_q;
					chk_fire    = 1'b1;
					if (!armed_q) begin
						fire_anchor_d = pos;
					end
				end else begin
					wd_chk      = !ep;
					edge_pend_d = 1'b0;
					if (ep && !armed_q) begin
						last_anchor_d = pos;
						fire_anchor_d = pos;
						armed_d       = 1'b1;
						if (skip_q) begin
							skip_d = 1'b0;
						end else begin
							slip_chk = 1'b1;
							armed_e  = 1'b1;
							reanch   = 1'b1;
							chk_fire = 1'b1;
						end
					end else begin
						chk_fire = 1'b1;
					end
				end
			end
			default: ;
		endcase

		// a fresh anchor is at distance zero
		fire = chk_fire && armed_e && (reanch ? step_zero : fire_far);
		if (fire) begin
			armed_d = 1'b0;
			if (cfg.shot_total == '0) begin
				fire_tot_d = fire_tot_q + 1'b1;
			end else if (shot_inc >= cfg.shot_total) begin
				fire_pause = 1'b1;
				run_d      = 1'b0;
				shot_d     = '0;
			end else begin
				shot_d = shot_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_pend_q   <= 1'b0;
			run_q         <= 1'b0;
			skip_q        <= 1'b1;
			armed_q       <= 1'b0;
			last_anchor_q <= '0;
			fire_anchor_q <= '0;
			shot_q        <= '0;
			fire_tot_q    <= '0;
			stray_q       <= '0;
		end else if (pop) begin
			edge_pend_q   <= edge_pend_d;
			run_q         <= run_d;
			skip_q        <= skip_d;
			armed_q       <= armed_d;
			last_anchor_q <= last_anchor_d;
			fire_anchor_q <= fire_anchor_d;
			shot_q        <= shot_d;
			fire_tot_q    <= fire_tot_d;
			stray_q       <= stray_d;
		end
	end

	assign d_neg = -d_s2;
	assign abs_d = d_s2[PW] ? d_neg[PW-1:0] : d_s2[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s2 <= pop;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stat_s2.fire       <= fire;
			stat_s2.fire_pause <= fire_pause;
			stat_s2.run        <= run_d;
			stat_s2.insp       <= fire_tot_d;
			stat_s2.shots      <= shot_d;
			stat_s2.stray      <= stray_d;
			d_s2               <= d_anchor;
			wd_chk_s2          <= wd_chk;
			slip_chk_s2        <= slip_chk;
			slip_clr_s2        <= slip_clr;

			stat_s3     <= stat_s2;
			abs_s3      <= abs_d;
			wd_hit_s3   <= wd_chk_s2 && (WATCH_W'(abs_d) > cfg.watch);
			slip_chk_s3 <= slip_chk_s2;
			slip_clr_s3 <= slip_clr_s2;

			stat_s4     <= stat_s3;
			act100_s4   <= (ACT_W'(abs_s3) << 6) + (ACT_W'(abs_s3) << 5)
				+ (ACT_W'(abs_s3) << 2);
			wd_hit_s4   <= wd_hit_s3;
			slip_chk_s4 <= slip_chk_s3;
			slip_clr_s4 <= slip_clr_s3;
		end
	end

	// 100*|actual - pitch| > pitch*tol  <=>  deviation above floor(pitch*tol/100)
	assign miss = (SCALE_W'(act100_s4) > cfg.hi)
		|| (cfg.lo_ok && (SCALE_W'(act100_s4) < cfg.lo));

	always_comb begin
		slip_d   = slip_q;
		slip_hit = 1'b0;
		if (slip_clr_s4) begin
			slip_d = '0;
		end else if (slip_chk_s4) begin
			if (miss) begin
				if (slip_q != '1) begin
					slip_d = slip_q + 1'b1;
				end
				slip_hit = (slip_d >= cfg.limit);
			end else begin
				slip_d = '0;
			end
		end
		if (slip_hit) begin
			err_d = ERR_SLIP;
		end else if (wd_hit_s4) begin
			err_d = ERR_MISSING;
		end else begin
			err_d = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slip_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s4;
			if (valid_s4) begin
				slip_q <= slip_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s4) begin
			fire_q      <= stat_s4.fire;
			pause_q     <= stat_s4.fire_pause || wd_hit_s4 || slip_hit;
			err_q       <= err_d;
			run_out_q   <= stat_s4.run;
			insp_q      <= stat_s4.insp;
			shots_q     <= stat_s4.shots;
			stray_out_q <= stat_s4.stray;
		end
	end

	assign out_valid        = out_valid_q;
	assign camera_fire      = fire_q;
	assign pause_request    = pause_q;
	assign error_code       = err_q;
	assign run_active       = run_out_q;
	assign inspection_count = insp_q;
	assign shots_taken      = shots_q;
	assign stray_edges      = stray_out_q;

endmodule

[sv/position_anchored_camera_trigger_top.sv]
// ---------------------------------------------------------------------------
// position_anchored_camera_trigger_top: camera trigger on motor position
// Anchors on sensor edges, fires the camera a step from the anchor.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per control tick:
//   operation (tick or start of run), position, sensor_edge, motor_paused.
//   Output channel (out_valid / out_stall) returns one result item per input
//   item, in order: camera_fire, pause_request, error_code, run_active and
//   the inspection, shot and stray-edge counters.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
//   only while no item is in flight. Derived products are registered.
//   From input accept to out_valid an item passes the front register, queue,
//   state stage, distance stage, scale stage and output register.
//   Throughput: one item per cycle while not stalled; run state is updated
//   in a single stage, so back-to-back items never wait on each other.
//   When the receiver stalls, the back pipeline holds and the 4-entry queue
//   plus the front register absorb items before in_stall rises.
//   Reset (arst_n low): run idle, skip set, edge latch clear, anchors and
//   counters zero, tolerance 10 percent, other cfg zero. No clearing pass.
// ---------------------------------------------------------------------------
module position_anchored_camera_trigger_top
	import pact_pkg::*;
#(
	parameter int DEFAULT_SLIP_LIMIT = 3,
	parameter int POSITION_BITS      = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [POS_W-1:0]      position,
	input  logic                  sensor_edge,
	input  logic                  motor_paused,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  camera_fire,
	output logic                  pause_request,
	output logic [1:0]            error_code,
	output logic                  run_active,
	output logic [FIRE_CNT_W-1:0] inspection_count,
	output logic [SHOT_W-1:0]     shots_taken,
	output logic [STRAY_W-1:0]    stray_edges,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	cfg_t    cfg;
	q_stat_t q_stat;
	logic    push;
	item_t   push_item;
	logic    pop;
	item_t   head;

	// configuration registers and derived thresholds
	pact_cfg #(
		.DEFAULT_SLIP_LIMIT(DEFAULT_SLIP_LIMIT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// front: accept and classify
	pact_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.position    (position),
		.sensor_edge (sensor_edge),
		.motor_paused(motor_paused),
		.q_stat      (q_stat),
		.push        (push),
		.push_item   (push_item)
	);

	// decoupling queue
	pact_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// back: run state, watchdog, slip check, output register
	pact_back #(
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.head            (head),
		.q_stat          (q_stat),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.camera_fire     (camera_fire),
		.pause_request   (pause_request),
		.error_code      (error_code),
		.run_active      (run_active),
		.inspection_count(inspection_count),
		.shots_taken     (shots_taken),
		.stray_edges     (stray_edges)
	);

	// any error also asks for a pause
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code != ERR_NONE) |-> pause_request)
		else $error("error reported without pause request");

	// a fire that ends the run is the last shot and must request a pause
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && camera_fire && !run_active |-> pause_request)
		else $error("run ended on fire without pause request");

	// the queue never takes an item while full
	assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("push into full queue");

endmodule
